/* rtl/core/jan_pkg.sv */
package jan_pkg;

  localparam int SampleBits = 10;
  localparam int FullScale = 16384;
  localparam int OffsetLimit = 1023;
  localparam int NumBits = 36;
  localparam int DenBits = 19;

  localparam logic [2:0] RegCenterX = 3'd0;
  localparam logic [2:0] RegCenterY = 3'd1;
  localparam logic [2:0] RegDeadZone = 3'd2;
  localparam logic [2:0] RegXRange = 3'd3;
  localparam logic [2:0] RegDownBoost = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFFS,
    ST_YMUL,
    ST_DIVX,
    ST_WAITX,
    ST_DIVY,
    ST_WAITY,
    ST_SQX,
    ST_WAITSX,
    ST_SQY,
    ST_WAITSY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

/* rtl/core/jan_divider.sv */
module jan_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [jan_pkg::NumBits-1:0] num,
  input  logic [jan_pkg::DenBits-1:0] den,
  output jan_pkg::div_ctl_t ctl,
  output logic [15:0] quo
);

  logic [jan_pkg::NumBits+1:0] dividend;
  logic [jan_pkg::DenBits+1:0] divisor;
  logic [jan_pkg::DenBits+2:0] rem;
  logic [jan_pkg::NumBits+1:0] q;
  logic [5:0] count;
  logic busy;
  logic done;
  logic [jan_pkg::DenBits+2:0] trial;

  // Rounded quotient: (2*num + den) / (2*den), restoring, one bit a cycle.
  assign trial = {rem[jan_pkg::DenBits+1:0], dividend[jan_pkg::NumBits+1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'(jan_pkg::NumBits + 2);
        dividend <= {num, 1'b0} + (jan_pkg::NumBits + 2)'(den);
        divisor <= {1'b0, den, 1'b0};
        rem <= '0;
        q <= '0;
      end else if (busy) begin
        dividend <= {dividend[jan_pkg::NumBits:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
          q <= {q[jan_pkg::NumBits:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[jan_pkg::NumBits:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = (q > (jan_pkg::NumBits + 2)'(jan_pkg::FullScale)) ? 16'(jan_pkg::FullScale)
             : q[15:0];
  assign ctl = '{start: start, busy: busy, done: done};

endmodule

/* rtl/core/joystick_axis_normalizer_unit.sv */
// Joystick axis normalizer.
// Input words arrive on s_axis: tdata holds sample_x then sample_y.
// Result words leave on m_axis: tdata holds norm_x, norm_y, offset_x, offset_y.
// Calibration registers are written through cfg_we, cfg_index, cfg_data.
// The user must write them only while the block is idle, which the block
// does not enforce; they take effect for the next sample.
// Each sample runs through one shared restoring divider four times
// (X scale, Y scale, and two square-mapping divides), or twice when the
// square mapping is skipped. One divide is a start, 38 quotient bits
// and a done strobe; two offset steps come before the divides.
// s_axis_tready is low from acceptance until the result has been taken.
// While m_axis_tready is low the result holds in its output register.
// Synchronous reset restores the default calibration, clears the Y
// extremes to full-scale low and zero high, and empties the output.
module joystick_axis_normalizer_unit (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // sample_x, sample_y
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [55:0] m_axis_tdata,  // norm_x, norm_y, offset_x, offset_y
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int SB = jan_pkg::SampleBits;

  logic [9:0] center_x, center_y, dead_zone, x_range;
  logic [11:0] down_boost;
  logic [SB-1:0] lowest_y, highest_y;
  logic [SB-1:0] sx, sy;
  jan_pkg::state_t state, state_next;
  logic signed [10:0] dx, dy;
  logic [15:0] ax, ay;
  logic sneg_x, sneg_y;
  logic [jan_pkg::NumBits-1:0] ynum;
  logic [jan_pkg::DenBits-1:0] yden;
  logic [jan_pkg::NumBits-1:0] d_num;
  logic [jan_pkg::DenBits-1:0] d_den;
  logic d_start;
  jan_pkg::div_ctl_t d_ctl;
  logic [15:0] d_quo;
  logic [15:0] mx;
  logic [15:0] m_sq;
  logic signed [15:0] nx, ny;

  function automatic logic signed [10:0] dz_off(input logic [SB-1:0] v, input logic [9:0] c,
                                                 input logic [9:0] dz);
    logic signed [SB+1:0] d;
    logic [SB+1:0] a;
    d = $signed({2'b00, v}) - $signed((SB + 2)'(c));
    a = d[SB+1] ? -d : d;
    if (a < (SB + 2)'(dz)) d = '0;
    if (d > (SB + 2)'(jan_pkg::OffsetLimit)) d = (SB + 2)'(jan_pkg::OffsetLimit);
    if (d < -$signed((SB + 2)'(jan_pkg::OffsetLimit)))
      d = -$signed((SB + 2)'(jan_pkg::OffsetLimit));
    return 11'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= 10'd512;
      center_y <= 10'd512;
      dead_zone <= 10'd40;
      x_range <= 10'd400;
      down_boost <= 12'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        jan_pkg::RegCenterX: center_x <= cfg_data[9:0];
        jan_pkg::RegCenterY: center_y <= cfg_data[9:0];
        jan_pkg::RegDeadZone: dead_zone <= cfg_data[9:0];
        jan_pkg::RegXRange: x_range <= cfg_data[9:0];
        jan_pkg::RegDownBoost: down_boost <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= jan_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    d_start = 1'b0;
    d_num = '0;
    d_den = '0;
    case (state)
      jan_pkg::ST_IDLE: if (s_axis_tvalid) state_next = jan_pkg::ST_OFFS;
      jan_pkg::ST_OFFS: state_next = jan_pkg::ST_YMUL;
      jan_pkg::ST_YMUL: state_next = jan_pkg::ST_DIVX;
      jan_pkg::ST_DIVX: begin
        d_start = 1'b1;
        d_num = jan_pkg::NumBits'(ax) << 14;
        d_den = (x_range == 10'd0) ? jan_pkg::DenBits'(1) : jan_pkg::DenBits'(x_range);
        state_next = jan_pkg::ST_WAITX;
      end
      jan_pkg::ST_WAITX: if (d_ctl.done) state_next = jan_pkg::ST_DIVY;
      jan_pkg::ST_DIVY: begin
        d_start = 1'b1;
        d_num = ynum;
        d_den = yden;
        state_next = jan_pkg::ST_WAITY;
      end
      jan_pkg::ST_WAITY: if (d_ctl.done)
        state_next = (ax > 16'd1 || d_quo > 16'd1) ? jan_pkg::ST_SQX : jan_pkg::ST_OUT;
      jan_pkg::ST_SQX: begin
        d_start = 1'b1;
        d_num = jan_pkg::NumBits'(ax) << 14;
        d_den = jan_pkg::DenBits'(mx);
        state_next = jan_pkg::ST_WAITSX;
      end
      jan_pkg::ST_WAITSX: if (d_ctl.done) state_next = jan_pkg::ST_SQY;
      jan_pkg::ST_SQY: begin
        d_start = 1'b1;
        d_num = jan_pkg::NumBits'(ay) << 14;
        d_den = jan_pkg::DenBits'(m_sq);
        state_next = jan_pkg::ST_WAITSY;
      end
      jan_pkg::ST_WAITSY: if (d_ctl.done) state_next = jan_pkg::ST_OUT;
      jan_pkg::ST_OUT: if (m_axis_tready) state_next = jan_pkg::ST_IDLE;
      default: state_next = jan_pkg::ST_IDLE;
    endcase
  end

  assign mx = (ax > ay) ? ax : ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_y <= '1;
      highest_y <= '0;
    end else if (state == jan_pkg::ST_OFFS) begin
      if (sy < lowest_y) lowest_y <= sy;
      if (sy > highest_y) highest_y <= sy;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      jan_pkg::ST_IDLE: begin
        sx <= s_axis_tdata[SB-1:0];
        sy <= s_axis_tdata[SB+9:10];
      end
      jan_pkg::ST_OFFS: begin
        dx <= dz_off(sx, center_x, dead_zone);
        dy <= dz_off(sy, center_y, dead_zone);
      end
      jan_pkg::ST_YMUL: begin
        logic [10:0] mdx;
        logic [10:0] rng;
        logic signed [SB+1:0] up, dn;
        mdx = dx[10] ? 11'(-dx) : 11'(dx);
        rng = (x_range == 10'd0) ? 11'd1 : {1'b0, x_range};
        ax <= 16'((mdx > rng) ? rng : mdx);
        sneg_x <= (dx > 0);
        up = $signed((SB + 2)'(center_y)) - $signed({2'b00, lowest_y});
        dn = $signed({2'b00, highest_y}) - $signed((SB + 2)'(center_y));
        if (up < 1) up = 1;
        if (dn < 1) dn = 1;
        if (!dy[10]) begin
          sneg_y <= 1'b1;
          ynum <= jan_pkg::NumBits'({12'd0, dy[9:0]} * {10'd0, down_boost}) << 14;
          yden <= jan_pkg::DenBits'(dn[SB:0]) << 8;
        end else begin
          sneg_y <= 1'b0;
          ynum <= jan_pkg::NumBits'(11'(-dy)) << 14;
          yden <= jan_pkg::DenBits'(up[SB:0]);
        end
      end
      jan_pkg::ST_WAITX: if (d_ctl.done) ax <= d_quo;
      jan_pkg::ST_WAITY: if (d_ctl.done) ay <= d_quo;
      jan_pkg::ST_SQX: m_sq <= mx;
      jan_pkg::ST_WAITSX: if (d_ctl.done) ax <= d_quo;
      jan_pkg::ST_WAITSY: if (d_ctl.done) ay <= d_quo;
      default: ;
    endcase
  end

  jan_divider u_div (
    .clk(clk), .rst(rst), .start(d_start), .num(d_num), .den(d_den),
    .ctl(d_ctl), .quo(d_quo)
  );

  assign nx = sneg_x ? -$signed(ax) : $signed(ax);
  assign ny = sneg_y ? -$signed(ay) : $signed(ay);

  assign s_axis_tready = (state == jan_pkg::ST_IDLE);
  assign m_axis_tvalid = (state == jan_pkg::ST_OUT);
  assign m_axis_tdata = {2'b00, dy, dx, ny, nx};

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != jan_pkg::ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && d_ctl.busy)) else $error("result shown while dividing");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped while stalled");
  a_mag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (ax <= 16'(jan_pkg::FullScale) && ay <= 16'(jan_pkg::FullScale)))
    else $error("magnitude above full scale");

endmodule
